// ----- design/vlc_pkg.sv -----
// Shared constants and types for the vector length clamp unit.
// No dependencies.
`timescale 1ns / 1ps

package vlc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COMP_WIDTH_DEF = 32;
  localparam int LEN_WIDTH      = 32;
  localparam int CFG_IDX_WIDTH  = 1;

  localparam logic [LEN_WIDTH-1:0] MAX_LENGTH_RST = 32'h0001_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_OP_MODE    = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_CLAMP     = 1'b0,
    MODE_NORMALIZE = 1'b1
  } op_mode_e;

endpackage

// ----- design/vector_length_clamp_unit.sv -----
// Vector length clamp / normalize unit, fully pipelined.
// Depends on vlc_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel: a vector (vec_x_i, vec_y_i, vec_z_i) is taken on a rising
//   edge with start_i high and busy_o low. busy_o is always low: a new request
//   may be issued every cycle.
//   Result channel: done_o is high for exactly one cycle with res_x_o, res_y_o,
//   res_z_o, length_o and rescaled_o. The receiver cannot stall; results come
//   out in request order.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 = op_mode,
//   1 = max_length) and cfg_data_i. cfg_ready_o is always high. Write only
//   while no request is in flight.
// Throughput: one request per cycle. QW = max(COMP_WIDTH, FRAC_BITS+1).
//   Stages: S0 capture, S1 squares, S2 sum of squares, the bit-per-stage
//   square root (COMP_WIDTH stages), the multiply register, the bit-per-stage
//   restoring divider (QW stages, three lanes each) and the output register.
// Reset: rst_ni clears all valid bits and loads op_mode = clamp,
//   max_length = 1.0; in-flight requests are dropped.
module vector_length_clamp_unit #(
  parameter int FRAC_BITS  = vlc_pkg::FRAC_BITS_DEF,
  parameter int COMP_WIDTH = vlc_pkg::COMP_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [COMP_WIDTH-1:0]      vec_x_i,
  input  logic signed [COMP_WIDTH-1:0]      vec_y_i,
  input  logic signed [COMP_WIDTH-1:0]      vec_z_i,
  output logic                              done_o,
  output logic signed [COMP_WIDTH-1:0]      res_x_o,
  output logic signed [COMP_WIDTH-1:0]      res_y_o,
  output logic signed [COMP_WIDTH-1:0]      res_z_o,
  output logic [vlc_pkg::LEN_WIDTH-1:0]     length_o,
  output logic                              rescaled_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vlc_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [vlc_pkg::LEN_WIDTH-1:0]     cfg_data_i
);

  localparam int W   = COMP_WIDTH;
  localparam int SW  = 2 * W;                 // sum of squares width
  localparam int KW  = vlc_pkg::LEN_WIDTH;    // scale factor width
  localparam int NW  = W + KW;                // dividend width
  localparam int QW  = (W > FRAC_BITS) ? W : FRAC_BITS + 1;
  localparam int LXW = (W > KW) ? W : KW;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------- configuration ----------------
  vlc_pkg::op_mode_e mode_q;
  logic [KW-1:0]     max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vlc_pkg::MODE_CLAMP;
      max_q  <= vlc_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (vlc_pkg::cfg_reg_e'(cfg_index_i))
        vlc_pkg::REG_OP_MODE:    mode_q <= vlc_pkg::op_mode_e'(cfg_data_i[0]);
        vlc_pkg::REG_MAX_LENGTH: max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [W-1:0] abs_f(input logic [W-1:0] v);
    abs_f = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // ---------------- S0: capture, magnitudes ----------------
  logic              s0_v_q;
  logic [2:0][W-1:0] s0_raw_q, s0_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_v_q <= 1'b0;
    else         s0_v_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    s0_raw_q <= {vec_z_i, vec_y_i, vec_x_i};
    s0_mag_q <= {abs_f(vec_z_i), abs_f(vec_y_i), abs_f(vec_x_i)};
  end

  // ---------------- S1: squares ----------------
  logic               s1_v_q;
  logic [2:0][W-1:0]  s1_raw_q;
  logic [2:0][SW-1:0] s1_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= s0_v_q;
  end

  always_ff @(posedge clk_i) begin
    s1_raw_q <= s0_raw_q;
    for (int l = 0; l < 3; l++) begin
      s1_sq_q[l] <= SW'(s0_mag_q[l]) * SW'(s0_mag_q[l]);
    end
  end

  // ---------------- S2: sum of squares ----------------
  logic              s2_v_q;
  logic [2:0][W-1:0] s2_raw_q;
  logic [SW-1:0]     s2_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else         s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    s2_raw_q <= s1_raw_q;
    s2_sum_q <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
  end

  // ---------------- square root: one root bit per stage ----------------
  // Keeps rem = n - root^2; trial = root*2^(i+1) + 2^(2i).
  logic              sq_v   [W+1];
  logic [2:0][W-1:0] sq_raw [W+1];
  logic [SW-1:0]     sq_rem [W+1];
  logic [W-1:0]      sq_root[W+1];

  assign sq_v[0]    = s2_v_q;
  assign sq_raw[0]  = s2_raw_q;
  assign sq_rem[0]  = s2_sum_q;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    localparam int I = W - 1 - j;
    logic [SW:0]   trial;
    logic          take;
    logic          v_q;
    logic [2:0][W-1:0] raw_q;
    logic [SW-1:0] rem_q;
    logic [W-1:0]  root_q;

    assign trial = ((SW + 1)'(sq_root[j]) << (I + 1)) + ((SW + 1)'(1) << (2 * I));
    assign take  = trial <= {1'b0, sq_rem[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else         v_q <= sq_v[j];
    end

    always_ff @(posedge clk_i) begin
      raw_q  <= sq_raw[j];
      rem_q  <= take ? (sq_rem[j] - trial[SW-1:0]) : sq_rem[j];
      root_q <= take ? (sq_root[j] | (W'(1) << I)) : sq_root[j];
    end

    assign sq_v[j+1]    = v_q;
    assign sq_raw[j+1]  = raw_q;
    assign sq_rem[j+1]  = rem_q;
    assign sq_root[j+1] = root_q;
  end

  // ---------------- decide and multiply ----------------
  logic [W-1:0]  len_c;
  logic          scale_c;
  logic [KW-1:0] k_c;

  assign len_c   = sq_root[W];
  assign scale_c = (len_c != '0) &&
                   ((mode_q == vlc_pkg::MODE_NORMALIZE) || (LXW'(len_c) > LXW'(max_q)));
  assign k_c     = (mode_q == vlc_pkg::MODE_NORMALIZE) ? (KW'(1) << FRAC_BITS) : max_q;

  logic               m_v_q;
  logic [2:0][W-1:0]  m_raw_q;
  logic [2:0][NW-1:0] m_num_q;
  logic [W-1:0]       m_len_q;
  logic               m_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else         m_v_q <= sq_v[W];
  end

  always_ff @(posedge clk_i) begin
    m_raw_q   <= sq_raw[W];
    m_len_q   <= len_c;
    m_scale_q <= scale_c;
    for (int l = 0; l < 3; l++) begin
      m_num_q[l] <= NW'(abs_f(sq_raw[W][l])) * NW'(k_c);
    end
  end

  // ---------------- divider: one quotient bit per stage, three lanes ----------------
  logic               dv_v    [QW+1];
  logic [2:0][W-1:0]  dv_raw  [QW+1];
  logic [2:0][NW-1:0] dv_num  [QW+1];
  logic [2:0][W-1:0]  dv_rem  [QW+1];
  logic [2:0][QW-1:0] dv_quo  [QW+1];
  logic [W-1:0]       dv_len  [QW+1];
  logic               dv_scale[QW+1];

  assign dv_v[0]     = m_v_q;
  assign dv_raw[0]   = m_raw_q;
  assign dv_num[0]   = m_num_q;
  assign dv_len[0]   = m_len_q;
  assign dv_scale[0] = m_scale_q;
  assign dv_quo[0]   = '0;
  // top dividend bits stay below len whenever scaling applies
  for (genvar l = 0; l < 3; l++) begin : g_rem0
    assign dv_rem[0][l] = W'(m_num_q[l] >> QW);
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [2:0][W:0]   trial;
    logic [2:0]        take;
    logic              v_q;
    logic [2:0][W-1:0] raw_q;
    logic [2:0][NW-1:0] num_q;
    logic [2:0][W-1:0] rem_q;
    logic [2:0][QW-1:0] quo_q;
    logic [W-1:0]      len_q;
    logic              scale_q;

    for (genvar l = 0; l < 3; l++) begin : g_lane
      assign trial[l] = {dv_rem[j][l], dv_num[j][l][B]};
      assign take[l]  = trial[l] >= {1'b0, dv_len[j]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else         v_q <= dv_v[j];
    end

    always_ff @(posedge clk_i) begin
      raw_q   <= dv_raw[j];
      num_q   <= dv_num[j];
      len_q   <= dv_len[j];
      scale_q <= dv_scale[j];
      for (int l = 0; l < 3; l++) begin
        rem_q[l] <= take[l] ? W'(trial[l] - {1'b0, dv_len[j]}) : trial[l][W-1:0];
        quo_q[l] <= dv_quo[j][l] | (QW'(take[l]) << B);
      end
    end

    assign dv_v[j+1]     = v_q;
    assign dv_raw[j+1]   = raw_q;
    assign dv_num[j+1]   = num_q;
    assign dv_rem[j+1]   = rem_q;
    assign dv_quo[j+1]   = quo_q;
    assign dv_len[j+1]   = len_q;
    assign dv_scale[j+1] = scale_q;
  end

  // ---------------- output: sign restore, saturation, pass-through ----------------
  localparam logic [QW:0] POS_LIM = ((QW + 1)'(1) << (W - 1)) - (QW + 1)'(1);
  localparam logic [QW:0] NEG_LIM = (QW + 1)'(1) << (W - 1);

  logic [2:0][W-1:0] res_c;
  logic [LXW-1:0]    len_x;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_raw[QW][l][W-1]) begin
        res_c[l] = ({1'b0, dv_quo[QW][l]} > NEG_LIM) ? W'(NEG_LIM) : W'(dv_quo[QW][l]);
        res_c[l] = ~res_c[l] + W'(1);
      end else begin
        res_c[l] = ({1'b0, dv_quo[QW][l]} > POS_LIM) ? W'(POS_LIM) : W'(dv_quo[QW][l]);
      end
      if (!dv_scale[QW]) begin
        res_c[l] = dv_raw[QW][l];
      end
    end
  end

  assign len_x = LXW'(dv_len[QW]);

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_v[QW];
  end

  always_ff @(posedge clk_i) begin
    res_x_o    <= res_c[0];
    res_y_o    <= res_c[1];
    res_z_o    <= res_c[2];
    length_o   <= (len_x > LXW'({KW{1'b1}})) ? '1 : len_x[KW-1:0];
    rescaled_o <= dv_scale[QW];
  end

  assign done_o = done_q;

endmodule
